// File: src/b40lc_pkg.sv
// ----------------------------------------------------------------------------
// b40lc_pkg
// Shared types, constants and character mapping functions for the base-40
// label codec.
// ----------------------------------------------------------------------------
package b40lc_pkg;

    localparam int MAX_CHARS   = 6;
    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int CODE_W      = 6;
    localparam int WEIGHT_W    = 27;
    localparam int COUNT_W     = 3;
    localparam int QUOT_W      = 27;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // floor(x / 40) = floor((x >> 3) * DIV5_MAGIC >> DIV5_SHIFT) for 32-bit x
    localparam int              DIV5_SHIFT = 34;
    localparam int              PROD_W     = (WORD_W - 3) + WORD_W;
    localparam logic [WORD_W-1:0] DIV5_MAGIC = 32'hCCCC_CCCD;

    localparam logic [CODE_W-1:0] CODE_NONE         = 6'd0;
    localparam logic [CODE_W-1:0] CODE_LETTER_FIRST = 6'd1;
    localparam logic [CODE_W-1:0] CODE_LETTER_LAST  = 6'd26;
    localparam logic [CODE_W-1:0] CODE_DIGIT_LAST   = 6'd36;
    localparam logic [CODE_W-1:0] CODE_DASH         = 6'd37;
    localparam logic [CODE_W-1:0] CODE_DOT          = 6'd38;
    localparam logic [CODE_W-1:0] CODE_SLASH        = 6'd39;
    localparam logic [CODE_W-1:0] OTHER_CODE        = 6'd38;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
    // letter code = byte - LO_BIAS (or - UP_BIAS), digit code = byte - DIGIT_BIAS
    localparam logic [CHAR_W-1:0] LO_BIAS    = 8'h60;
    localparam logic [CHAR_W-1:0] UP_BIAS    = 8'h40;
    localparam logic [CHAR_W-1:0] DIGIT_BIAS = 8'd21;

    typedef struct packed {
        logic              dec;
        logic              zero;
        logic              last;
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] word;
    } t_cmd;

    function automatic logic [CODE_W-1:0] to_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = CH_NUL;
        priority if (c == CH_NUL) begin
            t = CH_NUL;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            t = c - LO_BIAS;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            t = c - UP_BIAS;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - DIGIT_BIAS;
        end else if (c == CH_DASH) begin
            t = {2'b00, CODE_DASH};
        end else if (c == CH_DOT) begin
            t = {2'b00, CODE_DOT};
        end else if (c == CH_SLASH) begin
            t = {2'b00, CODE_SLASH};
        end else begin
            t = {2'b00, OTHER_CODE};
        end
        return t[CODE_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] from_code(input logic [CODE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = CH_NUL;
        priority if (d == CODE_NONE) begin
            c = CH_NUL;
        end else if (d <= CODE_LETTER_LAST) begin
            c = LO_BIAS + {2'b00, d};
        end else if (d <= CODE_DIGIT_LAST) begin
            c = DIGIT_BIAS + {2'b00, d};
        end else if (d == CODE_DASH) begin
            c = CH_DASH;
        end else if (d == CODE_DOT) begin
            c = CH_DOT;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

endpackage

// File: src/b40lc_in_if.sv
// ----------------------------------------------------------------------------
// b40lc_in_if
// Input item channel: op, label byte, last flag and packed word.
// ----------------------------------------------------------------------------
interface b40lc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [b40lc_pkg::CHAR_W-1:0]   char_in;
    logic                           last_in;
    logic [b40lc_pkg::WORD_W-1:0]   word_in;

    modport source(output valid, output op, output char_in, output last_in,
                   output word_in, input ready);
    modport sink(input valid, input op, input char_in, input last_in,
                 input word_in, output ready);
endinterface

// File: src/b40lc_out_if.sv
// ----------------------------------------------------------------------------
// b40lc_out_if
// Result item channel: packed word or decoded character.
// ----------------------------------------------------------------------------
interface b40lc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_word;
    logic [b40lc_pkg::WORD_W-1:0]   packed_word;
    logic [b40lc_pkg::CHAR_W-1:0]   char_out;
    logic                           last_out;

    modport source(output valid, output is_word, output packed_word,
                   output char_out, output last_out, input ready);
    modport sink(input valid, input is_word, input packed_word,
                 input char_out, input last_out, output ready);
endinterface

// File: src/b40lc_front.sv
// ----------------------------------------------------------------------------
// b40lc_front
// Accepts input items, maps label bytes to base-40 codes and holds the
// classified commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module b40lc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b40lc_in_if.sink           i_item,
    output logic               o_cmd_valid,
    output b40lc_pkg::t_cmd    o_cmd,
    input  logic               i_cmd_ready
);

    b40lc_pkg::t_cmd                    r_q [b40lc_pkg::QUEUE_DEPTH];
    logic [b40lc_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [b40lc_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [b40lc_pkg::QCNT_W-1:0]       r_count;

    b40lc_pkg::t_cmd                    w_cmd;
    logic                               w_push;
    logic                               w_pop;

    localparam logic [b40lc_pkg::QPTR_W-1:0] PTR_LAST =
        b40lc_pkg::QPTR_W'(b40lc_pkg::QUEUE_DEPTH - 1);
    localparam logic [b40lc_pkg::QCNT_W-1:0] CNT_FULL =
        b40lc_pkg::QCNT_W'(b40lc_pkg::QUEUE_DEPTH);

    always_comb begin
        w_cmd.dec  = i_item.op;
        w_cmd.zero = (i_item.char_in == b40lc_pkg::CH_NUL);
        w_cmd.last = i_item.last_in;
        w_cmd.code = b40lc_pkg::to_code(i_item.char_in);
        w_cmd.word = i_item.word_in;
    end

    assign i_item.ready = (r_count != CNT_FULL);
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_count != '0);
    assign o_cmd        = r_q[r_rd_ptr];
    assign w_pop        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/b40lc_back.sv
// ----------------------------------------------------------------------------
// b40lc_back
// Executes queued commands: accumulates encode characters into the packed
// word and splits decode words into base-40 characters, one per divide and emit step.
// ----------------------------------------------------------------------------
module b40lc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  b40lc_pkg::t_cmd    i_cmd,
    output logic               o_cmd_ready,
    b40lc_out_if.source        o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    localparam int W  = b40lc_pkg::WORD_W;
    localparam int WW = b40lc_pkg::WEIGHT_W;
    localparam int QW = b40lc_pkg::QUOT_W;
    localparam logic [b40lc_pkg::COUNT_W-1:0] CNT_MAX =
        b40lc_pkg::COUNT_W'(b40lc_pkg::MAX_CHARS);

    logic [1:0]                         r_state, n_state;
    // encode state
    logic [W-1:0]                       r_acc, n_acc;
    logic [WW-1:0]                      r_weight, n_weight;
    logic [b40lc_pkg::COUNT_W-1:0]      r_cnt, n_cnt;
    logic                               r_ended, n_ended;
    // decode state
    logic [W-1:0]                       r_word, n_word;
    logic [QW-1:0]                      r_quot, n_quot;
    logic                               r_first, n_first;
    // output register
    logic                               r_out_valid, n_out_valid;
    logic                               r_is_word, n_is_word;
    logic [W-1:0]                       r_packed, n_packed;
    logic [b40lc_pkg::CHAR_W-1:0]       r_char, n_char;
    logic                               r_last, n_last;

    logic                               w_out_free;
    logic                               w_take;
    logic [b40lc_pkg::CODE_W+WW-1:0]    w_term;
    logic [W-1:0]                       w_acc_add;
    logic [b40lc_pkg::COUNT_W-1:0]      w_cnt_inc;
    logic [WW-1:0]                      w_weight_x40;
    logic [b40lc_pkg::PROD_W-1:0]       w_prod;
    logic [W-1:0]                       w_quot_x40;
    logic [W-1:0]                       w_rem;
    logic [b40lc_pkg::CODE_W-1:0]       w_digit;
    logic [b40lc_pkg::CHAR_W-1:0]       w_dchar;

    assign w_out_free  = !r_out_valid || o_result.ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_take      = i_cmd_valid && o_cmd_ready;

    // encode datapath
    assign w_term       = {{WW{1'b0}}, i_cmd.code} * {{b40lc_pkg::CODE_W{1'b0}}, r_weight};
    assign w_acc_add    = r_acc + w_term[W-1:0];
    assign w_cnt_inc    = r_cnt + 1'b1;
    assign w_weight_x40 = {r_weight[WW-6:0], 5'b0} + {r_weight[WW-4:0], 3'b0};

    // decode datapath: quotient by reciprocal, remainder in the next cycle
    assign w_prod     = {{(W-3){1'b0}}, b40lc_pkg::DIV5_MAGIC}
                      * {{W{1'b0}}, r_word[W-1:3]};
    assign w_quot_x40 = {r_quot, 5'b0} + {2'b0, r_quot, 3'b0};
    assign w_rem      = r_word - w_quot_x40;
    assign w_digit    = w_rem[b40lc_pkg::CODE_W-1:0];
    assign w_dchar    = b40lc_pkg::from_code(w_digit);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_weight    = r_weight;
        n_cnt       = r_cnt;
        n_ended     = r_ended;
        n_word      = r_word;
        n_quot      = r_quot;
        n_first     = r_first;
        n_out_valid = r_out_valid && !o_result.ready;
        n_is_word   = r_is_word;
        n_packed    = r_packed;
        n_char      = r_char;
        n_last      = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_cmd.dec) begin
                    n_word  = i_cmd.word;
                    n_first = 1'b1;
                    n_state = (i_cmd.word == '0) ? ST_TERM : ST_DIV;
                end else if (w_take) begin
                    if (i_cmd.zero) begin
                        n_ended = 1'b1;
                    end else if (!r_ended && r_cnt < CNT_MAX) begin
                        n_acc = w_acc_add;
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc < CNT_MAX) begin
                            n_weight = w_weight_x40;
                        end
                    end
                    if (i_cmd.last) begin
                        n_out_valid = 1'b1;
                        n_is_word   = 1'b1;
                        n_packed    = n_acc;
                        n_char      = b40lc_pkg::CH_NUL;
                        n_last      = 1'b1;
                        // back to the empty label
                        n_acc       = '0;
                        n_weight    = WW'(1);
                        n_cnt       = '0;
                        n_ended     = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                n_quot  = w_prod[b40lc_pkg::DIV5_SHIFT +: QW];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_is_word   = 1'b0;
                    n_packed    = '0;
                    n_last      = 1'b0;
                    n_char      = w_dchar;
                    // uppercase only the first letter of the label
                    if (r_first && w_digit >= b40lc_pkg::CODE_LETTER_FIRST
                        && w_digit <= b40lc_pkg::CODE_LETTER_LAST) begin
                        n_char  = w_dchar & ~b40lc_pkg::CASE_BIT;
                        n_first = 1'b0;
                    end
                    n_word  = {{(W-QW){1'b0}}, r_quot};
                    n_state = (r_quot == '0) ? ST_TERM : ST_DIV;
                end
            end
            ST_TERM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_is_word   = 1'b0;
                    n_packed    = '0;
                    n_char      = b40lc_pkg::CH_NUL;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_weight    <= WW'(1);
            r_cnt       <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_weight    <= n_weight;
            r_cnt       <= n_cnt;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_quot    <= n_quot;
        r_first   <= n_first;
        r_is_word <= n_is_word;
        r_packed  <= n_packed;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.is_word     = r_is_word;
    assign o_result.packed_word = r_packed;
    assign o_result.char_out    = r_char;
    assign o_result.last_out    = r_last;

endmodule

// File: src/base40_label_codec_core.sv
// ----------------------------------------------------------------------------
// base40_label_codec_core
// Two-way base-40 codec for short labels: packs up to six characters into a
// 32-bit word, and unpacks a word into characters with a zero terminator.
//
//   channel    direction  payload
//   i_item     in         op, char_in, last_in, word_in
//   o_result   out        is_word, packed_word, char_out, last_out
//
// An encode item is taken when the back end is idle and the output register is
// free; the word result is loaded into the output register at the edge that
// takes the item marked last from the queue.
// A decode item of D digits (up to 7) visits a divide state for the reciprocal
// multiply and an emit state for the remainder per digit, then a terminator state.
// A stalled result holds the back end; the two-entry queue then fills and
// drops input ready. Synchronous active-low reset empties the queue and
// clears the encoder.
// ----------------------------------------------------------------------------
module base40_label_codec_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b40lc_in_if.sink        i_item,
    b40lc_out_if.source     o_result
);

    logic               w_cmd_valid;
    logic               w_cmd_ready;
    b40lc_pkg::t_cmd    w_cmd;

    b40lc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    b40lc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_result    (o_result)
    );

endmodule

// File: verif/base40_label_codec_core_tb.sv
// ----------------------------------------------------------------------------
// base40_label_codec_core_tb
// Self-checking bench for the base-40 label codec. Label bytes and packed
// words go in through the item channel with random idle bursts. Results are
// compared field by field against a local model of the encoder and decoder,
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module base40_label_codec_core_tb;

    localparam int WORD_W    = b40lc_pkg::WORD_W;
    localparam int CHAR_W    = b40lc_pkg::CHAR_W;
    localparam int CODE_W    = b40lc_pkg::CODE_W;
    localparam int WEIGHT_W  = b40lc_pkg::WEIGHT_W;
    localparam int COUNT_W   = b40lc_pkg::COUNT_W;
    localparam int MAX_CHARS = b40lc_pkg::MAX_CHARS;

    localparam logic [CODE_W-1:0] CODE_NONE         = b40lc_pkg::CODE_NONE;
    localparam logic [CODE_W-1:0] CODE_LETTER_FIRST = b40lc_pkg::CODE_LETTER_FIRST;
    localparam logic [CODE_W-1:0] CODE_LETTER_LAST  = b40lc_pkg::CODE_LETTER_LAST;
    localparam logic [CODE_W-1:0] CODE_DIGIT_LAST   = b40lc_pkg::CODE_DIGIT_LAST;
    localparam logic [CODE_W-1:0] CODE_DASH         = b40lc_pkg::CODE_DASH;
    localparam logic [CODE_W-1:0] CODE_DOT          = b40lc_pkg::CODE_DOT;
    localparam logic [CODE_W-1:0] CODE_SLASH        = b40lc_pkg::CODE_SLASH;
    localparam logic [CODE_W-1:0] OTHER_CODE        = b40lc_pkg::OTHER_CODE;

    localparam logic [CHAR_W-1:0] CH_NUL   = b40lc_pkg::CH_NUL;
    localparam logic [CHAR_W-1:0] CH_LO_A  = b40lc_pkg::CH_LO_A;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = b40lc_pkg::CH_LO_Z;
    localparam logic [CHAR_W-1:0] CH_UP_A  = b40lc_pkg::CH_UP_A;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = b40lc_pkg::CH_UP_Z;
    localparam logic [CHAR_W-1:0] CH_ZERO  = b40lc_pkg::CH_ZERO;
    localparam logic [CHAR_W-1:0] CH_NINE  = b40lc_pkg::CH_NINE;
    localparam logic [CHAR_W-1:0] CH_DASH  = b40lc_pkg::CH_DASH;
    localparam logic [CHAR_W-1:0] CH_DOT   = b40lc_pkg::CH_DOT;
    localparam logic [CHAR_W-1:0] CH_SLASH = b40lc_pkg::CH_SLASH;
    localparam logic [CHAR_W-1:0] CASE_BIT = b40lc_pkg::CASE_BIT;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam int RADIX        = 40;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    // largest value with six base-40 digits
    localparam logic [WORD_W-1:0] SIX_DIGIT_MAX = 32'd4095999999;

    typedef struct packed {
        logic              is_word;
        logic [WORD_W-1:0] packed_word;
        logic [CHAR_W-1:0] char_out;
        logic              last_out;
    } t_codec_result;

    logic i_clk;
    logic i_rst_n;

    b40lc_in_if  item_if ();
    b40lc_out_if result_if ();

    base40_label_codec_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // label packing state of the model
    logic [WORD_W-1:0]   label_acc;
    logic [WEIGHT_W-1:0] label_weight;
    logic [COUNT_W-1:0]  label_count;
    logic                label_ended;

    t_codec_result pending_results[$];

    int  errors;
    int  items_accepted;
    int  results_checked;
    int  labels_packed;
    int  words_decoded;
    int  cycles;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        if (c == CH_NUL) begin
            t = 8'd0;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            t = c - CH_LO_A + 8'd1;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            t = c - CH_UP_A + 8'd1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO + 8'(CODE_LETTER_LAST) + 8'd1;
        end else if (c == CH_DASH) begin
            t = 8'(CODE_DASH);
        end else if (c == CH_DOT) begin
            t = 8'(CODE_DOT);
        end else if (c == CH_SLASH) begin
            t = 8'(CODE_SLASH);
        end else begin
            t = 8'(OTHER_CODE);
        end
        return t[CODE_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] d);
        if (d == CODE_NONE)
            return CH_NUL;
        if (d <= CODE_LETTER_LAST)
            return CH_LO_A + 8'(d) - 8'd1;
        if (d <= CODE_DIGIT_LAST)
            return CH_ZERO + 8'(d) - 8'(CODE_LETTER_LAST) - 8'd1;
        if (d == CODE_DASH)
            return CH_DASH;
        if (d == CODE_DOT)
            return CH_DOT;
        return CH_SLASH;
    endfunction

    function automatic void clear_label();
        label_acc    = '0;
        label_weight = WEIGHT_W'(1);
        label_count  = '0;
        label_ended  = 1'b0;
    endfunction

    function automatic void predict_codec(input logic op, input logic [CHAR_W-1:0] ch,
                                          input logic last, input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] rest;
        logic [CODE_W-1:0] digit;
        logic [CHAR_W-1:0] c;
        bit                cap_pending;
        if (op == OP_ENCODE) begin
            if (ch == CH_NUL) begin
                label_ended = 1'b1;
            end else if (!label_ended && label_count < MAX_CHARS) begin
                label_acc   = label_acc + WORD_W'(char_code(ch)) * WORD_W'(label_weight);
                label_count = label_count + 1'b1;
                if (label_count < MAX_CHARS)
                    label_weight = WEIGHT_W'(WORD_W'(label_weight) * RADIX);
            end
            if (last) begin
                pending_results.push_back(t_codec_result'{1'b1, label_acc, CH_NUL, 1'b1});
                clear_label();
                labels_packed++;
            end
        end else begin
            rest = word;
            cap_pending = 1'b1;
            while (rest != '0) begin
                digit = CODE_W'(rest % RADIX);
                rest  = rest / RADIX;
                c = code_char(digit);
                // uppercase only the first letter of the label
                if (cap_pending && digit >= CODE_LETTER_FIRST && digit <= CODE_LETTER_LAST) begin
                    c = c & ~CASE_BIT;
                    cap_pending = 1'b0;
                end
                pending_results.push_back(t_codec_result'{1'b0, '0, c, 1'b0});
            end
            pending_results.push_back(t_codec_result'{1'b0, '0, CH_NUL, 1'b1});
            words_decoded++;
        end
    endfunction

    // check the result side first, then predict the accepted item
    always @(posedge i_clk) begin : scoreboard
        t_codec_result want;
        if (!i_rst_n) begin
            clear_label();
        end else begin
            if (result_if.valid && result_if.ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: is_word %0b packed_word %h char_out %h last_out %0b",
                           result_if.is_word, result_if.packed_word, result_if.char_out,
                           result_if.last_out);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (result_if.is_word !== want.is_word) begin
                        $error("is_word: expected %0b, got %0b", want.is_word, result_if.is_word);
                        errors++;
                    end
                    if (result_if.packed_word !== want.packed_word) begin
                        $error("packed_word: expected %h, got %h", want.packed_word,
                               result_if.packed_word);
                        errors++;
                    end
                    if (result_if.char_out !== want.char_out) begin
                        $error("char_out: expected %h, got %h", want.char_out, result_if.char_out);
                        errors++;
                    end
                    if (result_if.last_out !== want.last_out) begin
                        $error("last_out: expected %0b, got %0b", want.last_out,
                               result_if.last_out);
                        errors++;
                    end
                end
            end
            if (item_if.valid && item_if.ready) begin
                items_accepted++;
                predict_codec(item_if.op, item_if.char_in, item_if.last_in, item_if.word_in);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("base40_label_codec_core_tb NOT OK");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin : result_stall
        int gap;
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 12);
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch, input logic last,
                             input logic [WORD_W-1:0] word);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.op      <= op;
        item_if.char_in <= ch;
        item_if.last_in <= last;
        item_if.word_in <= word;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    task automatic send_label(input logic [CHAR_W-1:0] chars[$]);
        for (int i = 0; i < chars.size(); i++)
            send_item(OP_ENCODE, chars[i], i == chars.size() - 1, $urandom());
    endtask

    task automatic send_decode(input logic [WORD_W-1:0] word);
        send_item(OP_DECODE, 8'($urandom()), 1'($urandom()), word);
    endtask

    function automatic logic [CHAR_W-1:0] pick_label_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CH_LO_A + 8'($urandom_range(0, 25));
            4:          return CH_UP_A + 8'($urandom_range(0, 25));
            5:          return CH_ZERO + 8'($urandom_range(0, 9));
            6:          return CH_DASH + 8'($urandom_range(0, 2));
            7:          return 8'($urandom_range(0, 255));
            8:          return 8'($urandom_range(128, 255));
            default:    return ($urandom_range(0, 2) == 0) ? CH_NUL : 8'($urandom_range(1, 127));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] scale;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, SIX_DIGIT_MAX);
            2: return $urandom_range(0, 1600);
            3: begin
                // digits with frequent zeros inside
                w = '0;
                scale = 32'd1;
                for (int i = 0; i < MAX_CHARS; i++) begin
                    if ($urandom_range(0, 2) != 0)
                        w = w + scale * $urandom_range(1, RADIX - 1);
                    scale = scale * RADIX;
                end
                return w;
            end
            4: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom_range(SIX_DIGIT_MAX + 1, 32'hFFFF_FFFF);
        endcase
    endfunction

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // every character class, then an overlong label of unmapped bytes
    task automatic test_encode_mapping();
        logic [CHAR_W-1:0] lbl[$];
        lbl = '{CH_UP_A, CH_LO_Z, CH_NINE, CH_DASH, CH_DOT, CH_SLASH};
        send_label(lbl);
        lbl = '{8'hFF, 8'h80, 8'h40, 8'h7B, 8'h60, 8'h5B, 8'h3A};
        send_label(lbl);
    endtask

    // zero byte mid-label, zero byte on the last item, empty label
    task automatic test_encode_zero_byte();
        logic [CHAR_W-1:0] lbl[$];
        lbl = '{8'h71, CH_NUL, 8'h72};
        send_label(lbl);
        lbl = '{8'h6B, CH_NUL};
        send_label(lbl);
        lbl = '{CH_NUL};
        send_label(lbl);
    endtask

    // decodes between label bytes leave the label alone
    task automatic test_decode_inside_label();
        send_item(OP_ENCODE, 8'h6D, 1'b0, '1);
        send_decode('0);
        send_decode('1);
        send_item(OP_ENCODE, 8'h4E, 1'b1, '0);
    endtask

    // zero digit inside a word; first letter after a digit
    task automatic test_decode_digits();
        send_decode(32'd1601);
        send_decode(32'd67);
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        send_item(OP_ENCODE, pick_label_char(), i == len - 1, $urandom());
                        sent++;
                        // break the label with a stray decode now and then
                        if (i < len - 1 && $urandom_range(0, 9) == 0) begin
                            send_decode(pick_word());
                            sent++;
                        end
                    end
                end
                6, 7, 8: begin
                    send_decode(pick_word());
                    sent++;
                end
                default: begin
                    send_item(1'($urandom()), 8'($urandom()), 1'($urandom()), $urandom());
                    sent++;
                end
            endcase
        end
        item_if.valid <= 1'b0;
    endtask

    initial begin
        errors          = 0;
        items_accepted  = 0;
        results_checked = 0;
        labels_packed   = 0;
        words_decoded   = 0;
        cycles          = 0;
        idle_on         = 1'b1;
        clear_label();
        i_rst_n         <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.op      <= OP_ENCODE;
        item_if.char_in <= CH_NUL;
        item_if.last_in <= 1'b0;
        item_if.word_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_mapping();
        test_encode_zero_byte();
        test_decode_inside_label();
        test_decode_digits();
        test_random_traffic();
        wait_for_drain();

        $display("covered %0d items: %0d labels packed, %0d words decoded",
                 items_accepted, labels_packed, words_decoded);
        $display("checked %0d results against the model, %0d mismatches",
                 results_checked, errors);
        if (errors == 0) begin
            $display("base40_label_codec_core_tb OK");
        end else begin
            $display("base40_label_codec_core_tb NOT OK");
        end
        $finish;
    end

endmodule
